// ===== sv/point_to_two_segments_distance_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the point to two segments distance block
// Shared wrappers for the concurrent checks used by the port checker.
// ---------------------------------------------------------------------------
`ifndef POINT_TO_TWO_SEGMENTS_DISTANCE_MACROS_SVH
`define POINT_TO_TWO_SEGMENTS_DISTANCE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define P2SD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define P2SD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/p2sd_pkg.sv =====
// ---------------------------------------------------------------------------
// p2sd_pkg
// Register indexes and port constants for the segment distance block.
// ---------------------------------------------------------------------------
package p2sd_pkg;

   // Width of the register index on the configuration port.
   localparam int CSR_IDX_BITS = 4;

   // Register map of the two segments.
   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_A_START_X = 4'd0,
      REG_A_START_Y = 4'd1,
      REG_A_END_X   = 4'd2,
      REG_A_END_Y   = 4'd3,
      REG_B_START_X = 4'd4,
      REG_B_START_Y = 4'd5,
      REG_B_END_X   = 4'd6,
      REG_B_END_Y   = 4'd7
   } reg_idx_type;

endpackage

// ===== sv/p2sd_seg.sv =====
// ---------------------------------------------------------------------------
// p2sd_seg
// Pipelined distance from a query point to one segment: differences,
// products, endpoint tests, a restoring divider with one quotient bit per
// stage and a square root with one result bit per stage.
// ---------------------------------------------------------------------------
module p2sd_seg #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 4,
   localparam int DIST_BITS = COORD_BITS + FRAC_BITS + 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         ce,
   input  logic                         in_valid,
   input  logic signed [COORD_BITS-1:0] query_x,
   input  logic signed [COORD_BITS-1:0] query_y,
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   output logic                         out_valid,
   output logic [DIST_BITS-1:0]         dist_out
);

   localparam int DW = COORD_BITS + 1;           // coordinate difference
   localparam int SW = 2 * COORD_BITS + 1;       // squared length
   localparam int QW = SW + 2 * FRAC_BITS;       // quotient (squared distance)
   localparam int NW = 2 * SW + 2 * FRAC_BITS;   // dividend
   localparam int RW = DIST_BITS;                // root
   localparam int XW = 2 * RW;                   // radicand

   // Stage 1: coordinate differences.
   logic                 v1_ff;
   logic signed [DW-1:0] px_ff, py_ff, fx_ff, fy_ff, ux_ff, uy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ce) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         px_ff <= DW'(query_x) - DW'(start_x);
         py_ff <= DW'(query_y) - DW'(start_y);
         fx_ff <= DW'(query_x) - DW'(end_x);
         fy_ff <= DW'(query_y) - DW'(end_y);
         ux_ff <= DW'(end_x) - DW'(start_x);
         uy_ff <= DW'(end_y) - DW'(start_y);
      end
   end

   // Stage 2: squares and the two cross-product terms.
   logic                   v2_ff;
   logic signed [2*DW-1:0] pxx_ff, pyy_ff, fxx_ff, fyy_ff, uxx_ff, uyy_ff;
   logic signed [2*DW-1:0] cxy_ff, cyx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (ce) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         pxx_ff <= px_ff * px_ff;
         pyy_ff <= py_ff * py_ff;
         fxx_ff <= fx_ff * fx_ff;
         fyy_ff <= fy_ff * fy_ff;
         uxx_ff <= ux_ff * ux_ff;
         uyy_ff <= uy_ff * uy_ff;
         cxy_ff <= ux_ff * py_ff;
         cyx_ff <= uy_ff * px_ff;
      end
   end

   // Stage 3: squared side lengths and the cross product.
   logic                   v3_ff;
   logic [SW-1:0]          a2_ff, b2_ff, c2_ff;
   logic signed [2*DW-1:0] cr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (ce) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         a2_ff <= SW'(pxx_ff + pyy_ff);
         b2_ff <= SW'(fxx_ff + fyy_ff);
         c2_ff <= SW'(uxx_ff + uyy_ff);
         cr_ff <= cxy_ff - cyx_ff;
      end
   end

   // Stage 4: degenerate and endpoint tests, magnitude of the cross product.
   logic          v4_ff, zero4_ff, end_b4_ff, end_a4_ff;
   logic [SW-1:0] a2_4_ff, b2_4_ff, c2_4_ff, acr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (ce) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         zero4_ff  <= (c2_ff == '0);
         end_b4_ff <= (SW+1)'(a2_ff) >= (SW+1)'(b2_ff) + (SW+1)'(c2_ff);
         end_a4_ff <= (SW+1)'(b2_ff) >= (SW+1)'(a2_ff) + (SW+1)'(c2_ff);
         acr_ff    <= SW'((cr_ff < 0) ? -cr_ff : cr_ff);
         a2_4_ff   <= a2_ff;
         b2_4_ff   <= b2_ff;
         c2_4_ff   <= c2_ff;
      end
   end

   // Stage 5: square of the cross product, or the nearer endpoint's square.
   logic            v5_ff, zero5_ff, perp5_ff;
   logic [2*SW-1:0] crsq_ff;
   logic [SW-1:0]   endsq_ff, c2_5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (ce) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         zero5_ff <= zero4_ff;
         perp5_ff <= !end_b4_ff && !end_a4_ff;
         crsq_ff  <= acr_ff * acr_ff;
         endsq_ff <= end_b4_ff ? b2_4_ff : a2_4_ff;
         c2_5_ff  <= c2_4_ff;
      end
   end

   // Divider load: an endpoint case divides its square by one.
   logic [2*SW-1:0] nsel;
   logic [NW-1:0]   nfull;

   always_comb begin
      nsel  = perp5_ff ? crsq_ff : (2*SW)'(endsq_ff);
      nfull = NW'(nsel) << (2 * FRAC_BITS);
   end

   // Divider: stage k produces quotient bit QW-k.
   logic [SW-1:0] dv_rem_ff [0:QW];
   logic [QW-1:0] dv_nq_ff  [0:QW];
   logic [SW-1:0] dv_d_ff   [0:QW];
   logic          dv_z_ff   [0:QW];
   logic          dv_v_ff   [0:QW];
   logic [SW-1:0] dv_rem_in [1:QW];
   logic [QW-1:0] dv_nq_in  [1:QW];

   always_comb begin
      logic [SW:0] trial;
      logic        ge;
      for (int k = 1; k <= QW; k++) begin
         trial        = {dv_rem_ff[k-1], dv_nq_ff[k-1][QW-1]};
         ge           = trial >= {1'b0, dv_d_ff[k-1]};
         dv_rem_in[k] = ge ? SW'(trial - {1'b0, dv_d_ff[k-1]}) : SW'(trial);
         dv_nq_in[k]  = {dv_nq_ff[k-1][QW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QW; k++) begin
            dv_v_ff[k] <= 1'b0;
         end
      end else if (ce) begin
         dv_v_ff[0] <= v5_ff;
         for (int k = 1; k <= QW; k++) begin
            dv_v_ff[k] <= dv_v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         dv_rem_ff[0] <= nfull[NW-1:QW];
         dv_nq_ff[0]  <= nfull[QW-1:0];
         dv_d_ff[0]   <= perp5_ff ? c2_5_ff : SW'(1);
         dv_z_ff[0]   <= zero5_ff;
         for (int k = 1; k <= QW; k++) begin
            dv_rem_ff[k] <= dv_rem_in[k];
            dv_nq_ff[k]  <= dv_nq_in[k];
            dv_d_ff[k]   <= dv_d_ff[k-1];
            dv_z_ff[k]   <= dv_z_ff[k-1];
         end
      end
   end

   // Square root: stage k produces root bit RW-k.
   logic [RW+1:0] sq_rem_ff  [0:RW];
   logic [RW-1:0] sq_root_ff [0:RW];
   logic [XW-1:0] sq_x_ff    [0:RW];
   logic          sq_z_ff    [0:RW];
   logic          sq_v_ff    [0:RW];
   logic [RW+1:0] sq_rem_in  [1:RW];
   logic [RW-1:0] sq_root_in [1:RW];

   always_comb begin
      logic [RW+2:0] trem;
      logic [RW+2:0] trial;
      logic          ge;
      for (int k = 1; k <= RW; k++) begin
         trem          = {sq_rem_ff[k-1][RW:0], sq_x_ff[k-1][XW-1:XW-2]};
         trial         = {1'b0, sq_root_ff[k-1], 2'b01};
         ge            = trem >= trial;
         sq_rem_in[k]  = ge ? (RW+2)'(trem - trial) : (RW+2)'(trem);
         sq_root_in[k] = {sq_root_ff[k-1][RW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= RW; k++) begin
            sq_v_ff[k] <= 1'b0;
         end
      end else if (ce) begin
         sq_v_ff[0] <= dv_v_ff[QW];
         for (int k = 1; k <= RW; k++) begin
            sq_v_ff[k] <= sq_v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_x_ff[0]    <= XW'(dv_nq_ff[QW]);
         sq_z_ff[0]    <= dv_z_ff[QW];
         for (int k = 1; k <= RW; k++) begin
            sq_rem_ff[k]  <= sq_rem_in[k];
            sq_root_ff[k] <= sq_root_in[k];
            sq_x_ff[k]    <= sq_x_ff[k-1] << 2;
            sq_z_ff[k]    <= sq_z_ff[k-1];
         end
      end
   end

   // A zero-length segment reports distance zero.
   assign out_valid = sq_v_ff[RW];
   assign dist_out  = sq_z_ff[RW] ? '0 : sq_root_ff[RW];

endmodule

// ===== sv/point_to_two_segments_distance.sv =====
// ---------------------------------------------------------------------------
// point_to_two_segments_distance
// Distance from a stream of query points to two configured segments.
// ---------------------------------------------------------------------------
// Accepts one query point per cycle while req_tready is high and returns,
// in order, its distance to segment A and to segment B (unsigned,
// FRAC_BITS fraction bits, truncated), a flag that B is strictly nearer,
// and the smaller distance. A point passes five arithmetic stages, the
// divider with one quotient bit per stage, the square root with one result
// bit per stage and the output register. A two-beat output buffer keeps
// the pipeline moving while a result waits, so throughput is one point per
// cycle whenever the result side is ready. The user must write segments
// over the csr port only while no point is in flight; the block itself
// does not enforce this. A zero-length segment gives 0.
// ---------------------------------------------------------------------------
module point_to_two_segments_distance #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 4,
   localparam int DIST_BITS = COORD_BITS + FRAC_BITS + 1,
   localparam int REQ_BITS  = ((2 * COORD_BITS + 7) / 8) * 8,
   localparam int RSP_BITS  = ((3 * DIST_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // Query points: query_x, query_y.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [REQ_BITS-1:0]               req_tdata,
   // Results: dist_to_a, dist_to_b, min_dist.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [RSP_BITS-1:0]               rsp_tdata,
   // Result flag: nearer_is_b.
   output logic                              rsp_tuser,
   // Segment registers.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [p2sd_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]             csr_data
);

   import p2sd_pkg::*;

   localparam int OUT_BITS = 3 * DIST_BITS + 1;

   // Segment registers.
   logic signed [COORD_BITS-1:0] a_sx_ff, a_sy_ff, a_ex_ff, a_ey_ff;
   logic signed [COORD_BITS-1:0] b_sx_ff, b_sy_ff, b_ex_ff, b_ey_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_sx_ff <= '0;
         a_sy_ff <= '0;
         a_ex_ff <= '0;
         a_ey_ff <= '0;
         b_sx_ff <= '0;
         b_sy_ff <= '0;
         b_ex_ff <= '0;
         b_ey_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_A_START_X: a_sx_ff <= csr_data;
            REG_A_START_Y: a_sy_ff <= csr_data;
            REG_A_END_X:   a_ex_ff <= csr_data;
            REG_A_END_Y:   a_ey_ff <= csr_data;
            REG_B_START_X: b_sx_ff <= csr_data;
            REG_B_START_Y: b_sy_ff <= csr_data;
            REG_B_END_X:   b_ex_ff <= csr_data;
            REG_B_END_Y:   b_ey_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The pipeline advances whenever the skid register is free.
   logic skid_valid_ff;
   logic pipe_ce;
   logic in_beat;

   assign pipe_ce    = !skid_valid_ff;
   assign req_tready = pipe_ce;
   assign in_beat    = req_tvalid && pipe_ce;

   logic signed [COORD_BITS-1:0] query_x, query_y;
   assign query_x = req_tdata[COORD_BITS-1:0];
   assign query_y = req_tdata[2*COORD_BITS-1:COORD_BITS];

   logic                 va, vb;
   logic [DIST_BITS-1:0] dist_a, dist_b;

   p2sd_seg #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_seg_a (
      .clock    (clock),
      .reset    (reset),
      .ce       (pipe_ce),
      .in_valid (in_beat),
      .query_x  (query_x),
      .query_y  (query_y),
      .start_x  (a_sx_ff),
      .start_y  (a_sy_ff),
      .end_x    (a_ex_ff),
      .end_y    (a_ey_ff),
      .out_valid(va),
      .dist_out (dist_a)
   );

   p2sd_seg #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_seg_b (
      .clock    (clock),
      .reset    (reset),
      .ce       (pipe_ce),
      .in_valid (in_beat),
      .query_x  (query_x),
      .query_y  (query_y),
      .start_x  (b_sx_ff),
      .start_y  (b_sy_ff),
      .end_x    (b_ex_ff),
      .end_y    (b_ey_ff),
      .out_valid(vb),
      .dist_out (dist_b)
   );

   // Compare the two distances and pack the result beat.
   logic                pipe_valid;
   logic                b_nearer;
   logic [OUT_BITS-1:0] pipe_word;

   always_comb begin
      pipe_valid = va && vb;
      b_nearer   = dist_a > dist_b;
      pipe_word  = {b_nearer, (b_nearer ? dist_b : dist_a), dist_b, dist_a};
   end

   // Output register with a skid register behind it.
   logic                rsp_valid_ff;
   logic [OUT_BITS-1:0] rsp_word_ff, skid_word_ff;
   logic                rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_tready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (pipe_valid) begin
         if (rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            rsp_word_ff <= skid_word_ff;
         end
      end else if (pipe_valid) begin
         if (rsp_free) begin
            rsp_word_ff <= pipe_word;
         end else begin
            skid_word_ff <= pipe_word;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'(rsp_word_ff[3*DIST_BITS-1:0]);
   assign rsp_tuser  = rsp_word_ff[3*DIST_BITS];

endmodule

// ===== sv/p2sd_checker.sv =====
// ---------------------------------------------------------------------------
// p2sd_checker
// Port-level checks of the result channel of the segment distance block.
// ---------------------------------------------------------------------------
`include "point_to_two_segments_distance_macros.svh"

module p2sd_checker #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 4,
   localparam int DIST_BITS = COORD_BITS + FRAC_BITS + 1,
   localparam int RSP_BITS  = ((3 * DIST_BITS + 7) / 8) * 8
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_BITS-1:0] rsp_tdata,
   input logic                rsp_tuser
);

   logic [DIST_BITS-1:0] da, db, dm;
   logic [RSP_BITS:0]    rsp_beat;
   logic                 rsp_stall, flag_b, flag_a, min_ok;

   assign da = rsp_tdata[DIST_BITS-1:0];
   assign db = rsp_tdata[2*DIST_BITS-1:DIST_BITS];
   assign dm = rsp_tdata[3*DIST_BITS-1:2*DIST_BITS];

   // Qualified views of the result beat.
   assign rsp_beat  = {rsp_tuser, rsp_tdata};
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign flag_b    = rsp_tvalid && rsp_tuser;
   assign flag_a    = rsp_tvalid && !rsp_tuser;
   assign min_ok    = rsp_tuser ? (dm == db) : (dm == da);

   // A stalled result beat keeps its contents.
   `P2SD_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_beat), "stalled beat changed")

   // The flag says B is strictly nearer.
   `P2SD_ASSERT_NOW(a_flag_b, flag_b, db < da, "nearer_is_b set without a smaller B distance")

   // Without the flag, A is nearer or the distances tie.
   `P2SD_ASSERT_NOW(a_flag_a, flag_a, da <= db, "nearer_is_b clear although B is nearer")

   // The smaller distance is the one the flag selects.
   `P2SD_ASSERT_NOW(a_min_sel, rsp_tvalid, min_ok, "min_dist does not match the selection")

endmodule

bind point_to_two_segments_distance p2sd_checker #(
   .COORD_BITS(COORD_BITS),
   .FRAC_BITS (FRAC_BITS)
) u_p2sd_checker (.*);
